### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/spam_pkg.sv
// ---------------------------------------------------------------------------
// spam_pkg
// Types and fixed field widths of the sparse polynomial add/multiply core.
// ---------------------------------------------------------------------------
`default_nettype none

package spam_pkg;

	// Field widths of the term and result items
	localparam int COEFF_W   = 16;
	localparam int ACC_W     = 32;
	localparam int IN_EXP_W  = 4;
	localparam int OUT_EXP_W = 5;

	// Operand select codes
	localparam logic POLY_FIRST  = 1'b0;
	localparam logic POLY_SECOND = 1'b1;

	// Result kind codes
	localparam logic KIND_SUM     = 1'b0;
	localparam logic KIND_PRODUCT = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SUM_RD,
		S_SUM_CHK,
		S_PROD_RD,
		S_PROD_MUL,
		S_PROD_WR,
		S_EMIT_RD,
		S_EMIT_CHK,
		S_EMIT_FIN
	} state_t;

endpackage

`default_nettype wire

### design/spam_if.sv
// ---------------------------------------------------------------------------
// spam_term_if / spam_result_if
// Valid/ready channels for incoming polynomial terms and emitted result terms.
// ---------------------------------------------------------------------------
`default_nettype none

interface spam_term_if;
	import spam_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       poly_select;
	logic signed [COEFF_W-1:0]  coeff;
	logic [IN_EXP_W-1:0]        exponent;
	logic                       last_term;

	modport source (output valid, output poly_select, output coeff, output exponent,
		output last_term, input ready);
	modport sink (input valid, input poly_select, input coeff, input exponent,
		input last_term, output ready);
endinterface

interface spam_result_if;
	import spam_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic signed [ACC_W-1:0]    term_coeff;
	logic [OUT_EXP_W-1:0]       term_exponent;
	logic                       end_of_run;

	modport source (output valid, output result_kind, output term_coeff,
		output term_exponent, output end_of_run, input ready);
	modport sink (input valid, input result_kind, input term_coeff,
		input term_exponent, input end_of_run, output ready);
endinterface

`default_nettype wire

### design/spam_ram.sv
// ---------------------------------------------------------------------------
// spam_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module spam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wen,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     ren,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### design/spam_store.sv
// ---------------------------------------------------------------------------
// spam_store
// Coefficient store: a RAM plus one valid bit per entry, so that an entry
// never written since reset or the last clear reads as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module spam_store #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clear,
	input  wire logic                     wen,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     ren,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [DEPTH-1:0] valid_q;
	logic             rvalid_q;
	logic [WIDTH-1:0] ram_rdata;

	spam_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.ren   (ren),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Track written entries; clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wen) begin
				valid_q[waddr] <= 1'b1;
			end
			if (ren) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	// Mask stale entries to zero
	assign rdata = rvalid_q ? ram_rdata : '0;

endmodule

`default_nettype wire

### design/sparse_polynomial_add_multiply_core.sv
// ---------------------------------------------------------------------------
// sparse_polynomial_add_multiply_core
// Accumulates terms of two polynomials and emits their sum and product.
// ---------------------------------------------------------------------------
// Terms arrive on the terms channel, one item each, for the first or the
// second operand; equal exponents accumulate with 32-bit wrapping and zero
// coefficients or exponents above MAX_DEGREE are dropped. Each term item is
// read, then added and written back in the operand memory; no new item is
// taken before that write-back. On the item marked last the core emits the
// nonzero sum terms in descending exponent, then the nonzero product terms in
// descending exponent, with end_of_run on the final one; an empty sum or
// product comes out as one zero term. The closing phase runs the sum scan,
// then the product pass, where every operand pair does a read, multiply and
// write-back on the product memory, then the product scan; both scans wait
// while the results channel is stalled. Stores are cleared through per-entry
// valid bits, so there is no clearing pass after reset or between jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add_multiply_core #(
	parameter int MAX_DEGREE = 15
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	spam_term_if.sink     terms,
	spam_result_if.source results
);
	import spam_pkg::*;

	localparam int OPER_DEPTH = MAX_DEGREE + 1;
	localparam int PROD_DEPTH = 2 * MAX_DEGREE + 1;
	localparam int OW         = $clog2(OPER_DEPTH);
	localparam int PW         = $clog2(PROD_DEPTH);
	localparam logic [OW-1:0] TOP_OPER = OW'(MAX_DEGREE);
	localparam logic [PW-1:0] TOP_PROD = PW'(PROD_DEPTH - 1);

	state_t state_q, state_d;

	// Captured term
	logic             sel_q;
	logic [ACC_W-1:0] coeff_q;
	logic [OW-1:0]    exp_q;
	logic             last_q;
	logic             take_q;

	// Sequencing
	logic [OW-1:0]    i_q, j_q;
	logic [PW-1:0]    k_q;
	logic             any_q;
	logic [ACC_W-1:0] prod_q, acc_q;
	logic             pend_valid_q;
	logic [ACC_W-1:0] pend_coeff_q;
	logic [PW-1:0]    pend_exp_q;

	// Output register
	logic                 out_valid_q;
	logic                 out_kind_q, out_eor_q;
	logic [ACC_W-1:0]     out_coeff_q;
	logic [OUT_EXP_W-1:0] out_exp_q;

	// Store ports
	logic             a_ren, b_ren, p_ren, a_wen, b_wen, p_wen, store_clear;
	logic [OW-1:0]    a_raddr, b_raddr;
	logic [PW-1:0]    p_raddr;
	logic [ACC_W-1:0] a_rdata, b_rdata, p_rdata;

	// Datapath helpers
	logic                 accept, slot_free, sum_emit, p_nz, push;
	logic [ACC_W-1:0]     sum_val, load_val, p_wdata, mul_val;
	logic [PW-1:0]        pair_k;
	logic                 out_load, out_kind_d, out_eor_d;
	logic [ACC_W-1:0]     out_coeff_d;
	logic [OUT_EXP_W-1:0] out_exp_d;

	assign accept    = terms.valid && terms.ready;
	assign slot_free = !out_valid_q || results.ready;
	assign sum_val   = a_rdata + b_rdata;
	assign sum_emit  = (sum_val != '0) || ((i_q == '0) && !any_q);
	assign p_nz      = (p_rdata != '0);
	assign push      = p_nz && pend_valid_q;
	assign load_val  = ((sel_q == POLY_SECOND) ? b_rdata : a_rdata) + coeff_q;
	assign pair_k    = PW'(i_q) + PW'(j_q);
	assign p_wdata   = acc_q + prod_q;
	assign mul_val   = a_rdata * b_rdata;

	spam_store #(.WIDTH(ACC_W), .DEPTH(OPER_DEPTH)) u_first (
		.clk (clk), .arst_n (arst_n), .clear (store_clear),
		.wen (a_wen), .waddr (exp_q), .wdata (load_val),
		.ren (a_ren), .raddr (a_raddr), .rdata (a_rdata)
	);

	spam_store #(.WIDTH(ACC_W), .DEPTH(OPER_DEPTH)) u_second (
		.clk (clk), .arst_n (arst_n), .clear (store_clear),
		.wen (b_wen), .waddr (exp_q), .wdata (load_val),
		.ren (b_ren), .raddr (b_raddr), .rdata (b_rdata)
	);

	spam_store #(.WIDTH(ACC_W), .DEPTH(PROD_DEPTH)) u_product (
		.clk (clk), .arst_n (arst_n), .clear (store_clear),
		.wen (p_wen), .waddr (pair_k), .wdata (p_wdata),
		.ren (p_ren), .raddr (p_raddr), .rdata (p_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = last_q ? S_SUM_RD : S_IDLE;
			end
			S_SUM_RD: begin
				state_d = S_SUM_CHK;
			end
			S_SUM_CHK: begin
				if (!sum_emit || slot_free) begin
					state_d = (i_q == '0) ? S_PROD_RD : S_SUM_RD;
				end
			end
			S_PROD_RD: begin
				state_d = S_PROD_MUL;
			end
			S_PROD_MUL: begin
				state_d = S_PROD_WR;
			end
			S_PROD_WR: begin
				state_d = (i_q == TOP_OPER && j_q == TOP_OPER) ? S_EMIT_RD : S_PROD_RD;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_CHK;
			end
			S_EMIT_CHK: begin
				if (!push || slot_free) begin
					state_d = (k_q == '0) ? S_EMIT_FIN : S_EMIT_RD;
				end
			end
			S_EMIT_FIN: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs: memory strobes, addresses and output loads
	always_comb begin
		terms.ready = 1'b0;
		a_ren       = 1'b0;
		b_ren       = 1'b0;
		p_ren       = 1'b0;
		a_wen       = 1'b0;
		b_wen       = 1'b0;
		p_wen       = 1'b0;
		store_clear = 1'b0;
		a_raddr     = i_q;
		b_raddr     = i_q;
		p_raddr     = k_q;
		out_load    = 1'b0;
		out_kind_d  = KIND_SUM;
		out_coeff_d = sum_val;
		out_exp_d   = OUT_EXP_W'(i_q);
		out_eor_d   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				terms.ready = 1'b1;
				a_ren       = accept;
				b_ren       = accept;
				a_raddr     = OW'(terms.exponent);
				b_raddr     = OW'(terms.exponent);
			end
			S_LOAD: begin
				a_wen = take_q && (sel_q == POLY_FIRST);
				b_wen = take_q && (sel_q == POLY_SECOND);
			end
			S_SUM_RD: begin
				a_ren = 1'b1;
				b_ren = 1'b1;
			end
			S_SUM_CHK: begin
				out_load = sum_emit && slot_free;
			end
			S_PROD_RD: begin
				a_ren   = 1'b1;
				b_ren   = 1'b1;
				p_ren   = 1'b1;
				b_raddr = j_q;
				p_raddr = pair_k;
			end
			S_PROD_MUL: begin
			end
			S_PROD_WR: begin
				p_wen = 1'b1;
			end
			S_EMIT_RD: begin
				p_ren = 1'b1;
			end
			S_EMIT_CHK: begin
				out_load    = push && slot_free;
				out_kind_d  = KIND_PRODUCT;
				out_coeff_d = pend_coeff_q;
				out_exp_d   = OUT_EXP_W'(pend_exp_q);
			end
			S_EMIT_FIN: begin
				out_load    = slot_free;
				store_clear = slot_free;
				out_kind_d  = KIND_PRODUCT;
				out_coeff_d = pend_valid_q ? pend_coeff_q : '0;
				out_exp_d   = pend_valid_q ? OUT_EXP_W'(pend_exp_q) : '0;
				out_eor_d   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			any_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
		end else begin
			state_q <= state_d;

			// Hold a result until it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			// Advance the scan and pair counters
			case (state_q)
				S_LOAD: begin
					i_q   <= TOP_OPER;
					j_q   <= '0;
					any_q <= 1'b0;
				end
				S_SUM_CHK: begin
					if (out_load) any_q <= 1'b1;
					if (!sum_emit || slot_free) begin
						if (i_q != '0) i_q <= i_q - 1'b1;
					end
				end
				S_PROD_WR: begin
					if (j_q == TOP_OPER) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (i_q == TOP_OPER && j_q == TOP_OPER) begin
						k_q          <= TOP_PROD;
						pend_valid_q <= 1'b0;
					end
				end
				S_EMIT_CHK: begin
					if (!push || slot_free) begin
						if (p_nz) pend_valid_q <= 1'b1;
						if (k_q != '0) k_q <= k_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q   <= terms.poly_select;
			coeff_q <= ACC_W'(terms.coeff);
			exp_q   <= OW'(terms.exponent);
			last_q  <= terms.last_term;
			take_q  <= (terms.coeff != '0) && (int'(terms.exponent) <= MAX_DEGREE);
		end
		if (state_q == S_PROD_MUL) begin
			prod_q <= mul_val;
			acc_q  <= p_rdata;
		end
		if (state_q == S_EMIT_CHK && p_nz && (!push || slot_free)) begin
			pend_coeff_q <= p_rdata;
			pend_exp_q   <= k_q;
		end
		if (out_load) begin
			out_kind_q  <= out_kind_d;
			out_coeff_q <= out_coeff_d;
			out_exp_q   <= out_exp_d;
			out_eor_q   <= out_eor_d;
		end
	end

	// Drive the results channel
	assign results.valid         = out_valid_q;
	assign results.result_kind   = out_kind_q;
	assign results.term_coeff    = out_coeff_q;
	assign results.term_exponent = out_exp_q;
	assign results.end_of_run    = out_eor_q;

endmodule

`default_nettype wire

### design/spam_checker.sv
// ---------------------------------------------------------------------------
// spam_checker
// Port-level checks on the results channel of the add/multiply core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spam_checker #(
	parameter int MAX_DEGREE = 15
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic                           result_kind,
	input wire logic [spam_pkg::ACC_W-1:0]     term_coeff,
	input wire logic [spam_pkg::OUT_EXP_W-1:0] term_exponent,
	input wire logic                           end_of_run
);
	import spam_pkg::*;

	// A stalled result keeps its item
	`CHK_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(term_coeff) && $stable(term_exponent) && $stable(result_kind) && $stable(end_of_run), "stalled result changed")

	// Only a product term closes a run
	`CHK_IMPLY(a_eor_kind, result_valid && end_of_run, result_kind == KIND_PRODUCT, "end_of_run on a sum term")

	// A zero coefficient appears only as the empty-result term
	`CHK_IMPLY(a_zero_term, result_valid && (term_coeff == '0), term_exponent == '0, "zero term with nonzero exponent")

	// Sum terms stay within the operand degree
	`CHK_IMPLY(a_sum_degree, result_valid && (result_kind == KIND_SUM), int'(term_exponent) <= MAX_DEGREE, "sum exponent above degree")

endmodule

bind sparse_polynomial_add_multiply_core spam_checker #(
	.MAX_DEGREE (MAX_DEGREE)
) u_spam_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (results.valid),
	.result_ready  (results.ready),
	.result_kind   (results.result_kind),
	.term_coeff    (results.term_coeff),
	.term_exponent (results.term_exponent),
	.end_of_run    (results.end_of_run)
);

`default_nettype wire

### sim/sparse_polynomial_add_multiply_core_tb.sv
// ---------------------------------------------------------------------------
// sparse_polynomial_add_multiply_core_tb
// Self-checking bench: sends polynomial term items for both operands and
// checks every emitted sum and product term against a behavioral predictor.
// Directed jobs cover empty results, field extremes, cancellation and
// product wrap-around; random jobs follow, with random gaps on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add_multiply_core_tb;
	import spam_pkg::*;

	localparam int MAX_DEG      = 15;
	localparam int PROD_TOP     = 2 * MAX_DEG;
	localparam int MAX_WAIT     = 12;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 1000;

	typedef struct {
		logic                      poly_select;
		logic signed [COEFF_W-1:0] coeff;
		logic [IN_EXP_W-1:0]       exponent;
		logic                      last_term;
	} term_t;

	typedef struct {
		logic                   result_kind;
		logic [ACC_W-1:0]       term_coeff;
		logic [OUT_EXP_W-1:0]   term_exponent;
		logic                   end_of_run;
	} poly_term_t;

	logic clk;
	logic arst_n;

	spam_term_if   terms_ch ();
	spam_result_if results_ch ();

	sparse_polynomial_add_multiply_core #(
		.MAX_DEGREE(MAX_DEG)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.terms  (terms_ch),
		.results(results_ch)
	);

	// Operand coefficients as the block should hold them
	logic [ACC_W-1:0] first_coeffs  [0:MAX_DEG];
	logic [ACC_W-1:0] second_coeffs [0:MAX_DEG];
	poly_term_t       sum_product_q [$];

	int  mismatch_count = 0;
	int  terms_sent     = 0;
	int  results_seen   = 0;
	int  jobs_done      = 0;
	bit  no_gaps        = 1'b0;
	bit  no_stalls      = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic poly_term_t make_term(logic kind, logic [ACC_W-1:0] c, int e, logic eor);
		poly_term_t r;
		r.result_kind   = kind;
		r.term_coeff    = c;
		r.term_exponent = OUT_EXP_W'(e);
		r.end_of_run    = eor;
		return r;
	endfunction

	// Accumulate one term; on the last term queue the sum and product terms
	task automatic fold_term(input term_t t);
		logic [ACC_W-1:0] prod [0:PROD_TOP];
		logic [ACC_W-1:0] ext;
		logic [ACC_W-1:0] s;
		int               nsum;
		int               lowest;
		ext = {{(ACC_W-COEFF_W){t.coeff[COEFF_W-1]}}, t.coeff};
		if (t.coeff != 0 && int'(t.exponent) <= MAX_DEG) begin
			if (t.poly_select == POLY_FIRST)
				first_coeffs[t.exponent] += ext;
			else
				second_coeffs[t.exponent] += ext;
		end
		if (!t.last_term) return;

		// sum, highest power first; an empty sum is one zero term
		nsum = 0;
		for (int i = MAX_DEG; i >= 0; i--) begin
			s = first_coeffs[i] + second_coeffs[i];
			if (s != 0) begin
				sum_product_q.push_back(make_term(KIND_SUM, s, i, 1'b0));
				nsum++;
			end
		end
		if (nsum == 0)
			sum_product_q.push_back(make_term(KIND_SUM, '0, 0, 1'b0));

		// product by convolution, wrapping at the accumulator width
		for (int k = 0; k <= PROD_TOP; k++)
			prod[k] = '0;
		for (int i = 0; i <= MAX_DEG; i++)
			for (int j = 0; j <= MAX_DEG; j++)
				if (first_coeffs[i] != 0 && second_coeffs[j] != 0)
					prod[i + j] += first_coeffs[i] * second_coeffs[j];

		// end_of_run goes on the lowest nonzero power, emitted last
		lowest = -1;
		for (int k = PROD_TOP; k >= 0; k--)
			if (prod[k] != 0)
				lowest = k;
		for (int k = PROD_TOP; k >= 0; k--)
			if (prod[k] != 0)
				sum_product_q.push_back(make_term(KIND_PRODUCT, prod[k], k, k == lowest));
		if (lowest < 0)
			sum_product_q.push_back(make_term(KIND_PRODUCT, '0, 0, 1'b1));

		// drop both operands for the next job
		for (int i = 0; i <= MAX_DEG; i++) begin
			first_coeffs[i]  = '0;
			second_coeffs[i] = '0;
		end
		jobs_done++;
	endtask

	// Send one term item after a random gap; valid stays high afterwards
	task automatic send_term(input term_t t);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			terms_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		terms_ch.valid       <= 1'b1;
		terms_ch.poly_select <= t.poly_select;
		terms_ch.coeff       <= t.coeff;
		terms_ch.exponent    <= t.exponent;
		terms_ch.last_term   <= t.last_term;
		do @(posedge clk); while (terms_ch.ready !== 1'b1);
		terms_sent++;
		fold_term(t);
	endtask

	task automatic send(input logic sel, input int c, input int e, input logic last);
		term_t t;
		t.poly_select = sel;
		t.coeff       = COEFF_W'(c);
		t.exponent    = IN_EXP_W'(e);
		t.last_term   = last;
		send_term(t);
	endtask

	task automatic report_mismatch(input string what, input logic [ACC_W-1:0] want,
		input logic [ACC_W-1:0] got);
		$display("mismatch on result %0d: %s expected %0h got %0h", results_seen, what,
			want, got);
		mismatch_count++;
	endtask

	// Take result items with random stalls and check each against the queue
	initial begin : result_checker
		poly_term_t want;
		int         stall;
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (results_ch.valid !== 1'b1);
			results_seen++;
			if (sum_product_q.size() == 0) begin
				report_mismatch("unexpected term_coeff", '0, results_ch.term_coeff);
			end else begin
				want = sum_product_q.pop_front();
				if (results_ch.result_kind !== want.result_kind)
					report_mismatch("result_kind", ACC_W'(want.result_kind),
						ACC_W'(results_ch.result_kind));
				if (results_ch.term_coeff !== want.term_coeff)
					report_mismatch("term_coeff", want.term_coeff, results_ch.term_coeff);
				if (results_ch.term_exponent !== want.term_exponent)
					report_mismatch("term_exponent", ACC_W'(want.term_exponent),
						ACC_W'(results_ch.term_exponent));
				if (results_ch.end_of_run !== want.end_of_run)
					report_mismatch("end_of_run", ACC_W'(want.end_of_run),
						ACC_W'(results_ch.end_of_run));
			end
		end
	end

	// End the run when no item moves on either channel for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((terms_ch.valid === 1'b1 && terms_ch.ready === 1'b1) ||
				(results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no item moved for %0d cycles, %0d results pending", IDLE_LIMIT,
			sum_product_q.size());
		$display("FAILURE");
		$finish;
	end

	// Zero-only job: both the sum and the product come out as one zero term
	task automatic test_empty_job();
		send(POLY_FIRST, 0, 7, 1'b1);
	endtask

	// Largest magnitudes at the lowest and highest powers of both operands
	task automatic test_field_extremes();
		send(POLY_FIRST,  -32768, 15, 1'b0);
		send(POLY_FIRST,   32767,  0, 1'b0);
		send(POLY_SECOND, -32768, 15, 1'b0);
		send(POLY_SECOND,  32767,  0, 1'b1);
	endtask

	// Terms that cancel within an operand and across the sum
	task automatic test_cancellation();
		send(POLY_FIRST,     5, 3, 1'b0);
		send(POLY_SECOND,   -5, 3, 1'b0);
		send(POLY_FIRST,   100, 9, 1'b0);
		send(POLY_FIRST,  -100, 9, 1'b0);
		send(POLY_SECOND,    2, 1, 1'b1);
	endtask

	// Product that wraps to zero while the sum stays nonzero
	task automatic test_product_wrap();
		send(POLY_FIRST,  -32768, 0, 1'b0);
		send(POLY_FIRST,  -32768, 0, 1'b0);
		send(POLY_SECOND, -32768, 0, 1'b0);
		send(POLY_SECOND, -32768, 0, 1'b1);
	endtask

	// Only one operand present: empty product
	task automatic test_single_operand();
		send(POLY_SECOND, -1, 12, 1'b0);
		send(POLY_SECOND,  1,  4, 1'b1);
	endtask

	// One job of random terms; coefficients mix zero, extreme, small and wide
	task automatic run_random_job(input int len, input bit dense);
		term_t t;
		int    pick;
		int    prev_exp;
		prev_exp = 0;
		for (int k = 0; k < len; k++) begin
			pick          = $urandom_range(0, 15);
			t.poly_select = dense ? logic'(k / (MAX_DEG + 1)) : logic'($urandom_range(0, 1));
			if (dense)
				t.coeff = COEFF_W'($urandom_range(1, 65535));
			else if (pick < 2)
				t.coeff = '0;
			else if (pick < 4)
				t.coeff = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			else if (pick < 8)
				t.coeff = COEFF_W'(int'($urandom_range(0, 8)) - 4);
			else
				t.coeff = COEFF_W'($urandom);
			if (dense)
				t.exponent = IN_EXP_W'(k);
			else if ($urandom_range(0, 3) == 0)
				t.exponent = IN_EXP_W'(prev_exp);
			else
				t.exponent = IN_EXP_W'($urandom_range(0, MAX_DEG));
			prev_exp    = int'(t.exponent);
			t.last_term = (k == len - 1);
			send_term(t);
		end
	endtask

	task automatic test_random_jobs(input int total);
		int sent;
		int len;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(1, 10);
			run_random_job(len, 1'b0);
			sent += len;
		end
	endtask

	// Every power of both operands in use: the longest result list
	task automatic test_full_degree();
		run_random_job(2 * (MAX_DEG + 1), 1'b1);
	endtask

	// No gaps on either channel for one job
	task automatic test_back_to_back();
		no_gaps   = 1'b1;
		no_stalls = 1'b1;
		run_random_job(8, 1'b0);
		// drop valid so the last item is not taken again while draining
		terms_ch.valid <= 1'b0;
		while (sum_product_q.size() != 0) @(posedge clk);
		no_gaps   = 1'b0;
		no_stalls = 1'b0;
	endtask

	// Main sequence
	initial begin
		for (int i = 0; i <= MAX_DEG; i++) begin
			first_coeffs[i]  = '0;
			second_coeffs[i] = '0;
		end
		arst_n               <= 1'b0;
		terms_ch.valid       <= 1'b0;
		terms_ch.poly_select <= POLY_FIRST;
		terms_ch.coeff       <= '0;
		terms_ch.exponent    <= '0;
		terms_ch.last_term   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_job();
		test_field_extremes();
		test_cancellation();
		test_product_wrap();
		test_single_operand();
		test_full_degree();
		test_back_to_back();
		test_random_jobs(54);

		terms_ch.valid <= 1'b0;
		while (sum_product_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d term items in %0d jobs, checked %0d sum and product terms.",
			terms_sent, jobs_done, results_seen);
		$display("Mismatches found: %0d", mismatch_count);
		if (mismatch_count == 0 && sum_product_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
